### sv/upn_pkg.sv
// Shared package for the URI path normalizer.
// Holds command and status codes, character constants, the parse phase type
// and the result record types. Depends on nothing.
package upn_pkg;

  localparam int OUT_DEPTH_DEF     = 4096;
  localparam int MAX_SEGMENTS_DEF  = 128;
  localparam int SEGMENT_BYTES_DEF = 1024;

  localparam int CAP_W    = 13;
  localparam int CMD_W    = 2;
  localparam int CHAR_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 12;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [3:0] HEX_TEN    = 4'd10;

  typedef enum logic [2:0] {
    PH_WS,
    PH_PREFIX,
    PH_BODY,
    PH_STOP,
    PH_DONE
  } phase_t;

  // Result of one item as the parser sees it, before the read data arrives.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    out_length;
    logic                rd_hit;
  } res_info_t;

  // One finished result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    out_length;
    logic [CHAR_W-1:0]   read_byte;
  } res_item_t;

endpackage

### sv/upn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the output byte store and the segment start stack. No package.
module upn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/upn_write_queue.sv
// Small queue of output store writes: takes up to three per cycle, drains one.
// Depends on upn_pkg for the byte width.
module upn_write_queue #(
  parameter int AW = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [1:0]                       push_n,
  input  logic [2:0][AW-1:0]               push_addr,
  input  logic [2:0][upn_pkg::CHAR_W-1:0]  push_data,
  output logic [2:0]                       count,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [upn_pkg::CHAR_W-1:0]       ram_wdata
);
  import upn_pkg::*;

  logic [AW-1:0]     q_addr [4];
  logic [CHAR_W-1:0] q_data [4];
  logic [1:0]        head;
  logic [1:0]        tail;
  logic              pop;

  assign pop       = (count != 3'd0);
  assign ram_we    = pop;
  assign ram_waddr = q_addr[head];
  assign ram_wdata = q_data[head];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) begin
        q_addr[tail + 2'(i)] <= push_addr[i];
        q_data[tail + 2'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + push_n;
      head  <= head + 2'(pop);
      count <= count - 3'(pop) + 3'(push_n);
    end
  end

endmodule

### sv/upn_result_fifo.sv
// Four-entry result FIFO that drives the output channel.
// Depends on upn_pkg for the result item type.
module upn_result_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  upn_pkg::res_item_t           push_item,
  output logic [2:0]                   count,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [upn_pkg::STATUS_W-1:0] status,
  output logic [upn_pkg::LEN_W-1:0]    out_length,
  output logic [upn_pkg::CHAR_W-1:0]   read_byte
);
  import upn_pkg::*;

  res_item_t  q [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic       pop;

  assign out_valid  = (count != 3'd0);
  assign pop        = out_valid && out_ready;
  assign status     = q[head].status;
  assign out_length = q[head].out_length;
  assign read_byte  = q[head].read_byte;

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + 2'(push);
      head  <= head + 2'(pop);
      count <= count + 3'(push) - 3'(pop);
    end
  end

endmodule

### sv/upn_core.sv
// Parse state, capacity register and per-character normalizing logic.
// Depends on upn_pkg and instantiates upn_ram for the segment start stack.
module upn_core #(
  parameter int OUT_DEPTH     = upn_pkg::OUT_DEPTH_DEF,
  parameter int MAX_SEGMENTS  = upn_pkg::MAX_SEGMENTS_DEF,
  parameter int SEGMENT_BYTES = upn_pkg::SEGMENT_BYTES_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [upn_pkg::CAP_W-1:0]                 cfg_data,
  input  logic                                      accept,
  input  logic [upn_pkg::CMD_W-1:0]                 command,
  input  logic [upn_pkg::CHAR_W-1:0]                char_in,
  input  logic [upn_pkg::INDEX_W-1:0]               read_index,
  output upn_pkg::res_info_t                        info,
  output logic [1:0]                                wr_n,
  output logic [2:0][$clog2(OUT_DEPTH)-1:0]         wr_addr,
  output logic [2:0][upn_pkg::CHAR_W-1:0]           wr_data
);
  import upn_pkg::*;

  localparam int AW  = $clog2(OUT_DEPTH);
  localparam int OPW = $clog2(OUT_DEPTH + 1);
  localparam int SLW = $clog2(SEGMENT_BYTES);
  localparam int DW  = $clog2(MAX_SEGMENTS + 1);
  localparam int SIW = $clog2(MAX_SEGMENTS);
  localparam int PW  = $clog2(OUT_DEPTH + SEGMENT_BYTES + 2);
  localparam int EW  = ((CAP_W > OPW) ? CAP_W : OPW) + 1;
  localparam int IW  = ((INDEX_W > OPW) ? INDEX_W : OPW) + 1;

  typedef struct packed {
    phase_t          phase;
    logic [2:0]      pmc;
    logic            guard;
    logic [1:0]      esc;
    logic [3:0]      hn;
    logic            up;
    logic            rej;
    logic [OPW-1:0]  op;
    logic [SLW-1:0]  raw;
    logic [SLW-1:0]  trim;
    logic [15:0]     ft;
    logic [DW-1:0]   depth;
  } pstate_t;

  typedef struct packed {
    pstate_t                s;
    logic [1:0]             wn;
    logic [2:0][AW-1:0]     wa;
    logic [2:0][CHAR_W-1:0] wd;
    logic                   push;
    logic [OPW-1:0]         pushv;
    logic                   pop;
  } wk_t;

  function automatic pstate_t f_clear();
    pstate_t s;
    s       = '0;
    s.phase = PH_WS;
    s.guard = 1'b1;
    return s;
  endfunction

  function automatic logic is_ws(logic [7:0] b);
    return (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [7:0] d;
    d = 8'd16;
    if (b >= "0" && b <= "9") d = b - 8'h30;
    else if (b >= "a" && b <= "f") d = b - 8'h61 + 8'd10;
    else if (b >= "A" && b <= "F") d = b - 8'h41 + 8'd10;
    return d[4:0];
  endfunction

  function automatic logic [7:0] prefix_char(logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0: c = "f";
      2'd1: c = "i";
      2'd2: c = "l";
      default: c = "e";
    endcase
    return c;
  endfunction

  // Append one decoded byte to the segment under construction.
  function automatic wk_t f_seg(wk_t w, logic [7:0] b);
    logic [PW-1:0] pos;
    if (!w.s.rej) begin
      if (b == 8'd0 ||
          ((SLW+1)'(w.s.raw) + (SLW+1)'(1)) >= (SLW+1)'(SEGMENT_BYTES)) begin
        w.s.rej = 1'b1;
      end else begin
        pos = PW'(w.s.op) + PW'(w.s.op != '0) + PW'(w.s.raw);
        if (pos < PW'(OUT_DEPTH)) begin
          w.wa[w.wn] = pos[AW-1:0];
          w.wd[w.wn] = b;
          w.wn       = w.wn + 2'd1;
        end
        if (w.s.raw == '0) w.s.ft = {b, 8'h00};
        else if (w.s.raw == SLW'(1)) w.s.ft[7:0] = b;
        w.s.raw = w.s.raw + SLW'(1);
        if (!is_ws(b)) w.s.trim = w.s.raw;
      end
    end
    return w;
  endfunction

  // An escape that never completed is kept as literal text.
  function automatic wk_t f_flush(wk_t w);
    logic [1:0] p;
    logic [3:0] hv;
    logic [7:0] c;
    p       = w.s.esc;
    hv      = w.s.hn;
    w.s.esc = 2'd0;
    if (p != 2'd0) begin
      w = f_seg(w, CH_PERCENT);
      if (p == 2'd2) begin
        if (hv < HEX_TEN) c = 8'h30 + {4'h0, hv};
        else c = (w.s.up ? 8'h41 : 8'h61) + {4'h0, hv - HEX_TEN};
        w = f_seg(w, c);
      end
    end
    return w;
  endfunction

  // Close the current segment: drop, pop or commit it.
  function automatic wk_t f_fin(wk_t w, logic [OPW-1:0] top, logic [OPW-1:0] cap);
    logic [SLW-1:0] t;
    logic [7:0]     c0;
    logic [7:0]     c1;
    t      = w.s.trim;
    c0     = w.s.ft[15:8];
    c1     = w.s.ft[7:0];
    w.s.raw  = '0;
    w.s.trim = '0;
    w.s.ft   = '0;
    if (w.s.rej || t == '0) begin
      w.s.rej = w.s.rej;
    end else if (t == SLW'(1) && c0 == CH_DOT) begin
      w.s.rej = 1'b0;
    end else if (t == SLW'(2) && c0 == CH_DOT && c1 == CH_DOT) begin
      if (w.s.depth == '0) begin
        w.s.rej = 1'b1;
      end else begin
        w.s.depth = w.s.depth - DW'(1);
        w.s.op    = (top != '0) ? top - OPW'(1) : top;
        w.pop     = 1'b1;
      end
    end else if (DW'(w.s.depth) >= DW'(MAX_SEGMENTS)) begin
      w.s.rej = 1'b1;
    end else begin
      if (w.s.op != '0) begin
        if (PW'(w.s.op) + PW'(1) >= PW'(cap)) begin
          w.s.rej = 1'b1;
        end else begin
          w.wa[w.wn] = w.s.op[AW-1:0];
          w.wd[w.wn] = CH_SLASH;
          w.wn       = w.wn + 2'd1;
          w.s.op     = w.s.op + OPW'(1);
        end
      end
      if (!w.s.rej) begin
        if (PW'(t) + PW'(w.s.op) >= PW'(cap)) begin
          w.s.rej = 1'b1;
        end else begin
          w.push    = 1'b1;
          w.pushv   = w.s.op;
          w.s.depth = w.s.depth + DW'(1);
          w.s.op    = w.s.op + OPW'(t);
        end
      end
    end
    return w;
  endfunction

  function automatic wk_t f_body(wk_t w, logic [7:0] ch, logic [OPW-1:0] top,
                                 logic [OPW-1:0] cap);
    logic [4:0] h;
    logic       done;
    h    = hex_val(ch);
    done = 1'b0;
    if (w.s.esc != 2'd0) begin
      if (w.s.esc == 2'd1 && !h[4]) begin
        w.s.hn  = h[3:0];
        w.s.up  = (ch >= "A" && ch <= "F");
        w.s.esc = 2'd2;
        done    = 1'b1;
      end else if (w.s.esc == 2'd2 && !h[4]) begin
        w.s.esc = 2'd0;
        w       = f_seg(w, {w.s.hn, h[3:0]});
        done    = 1'b1;
      end else begin
        w = f_flush(w);
        if (w.s.rej) done = 1'b1;
      end
    end
    if (!done) begin
      if (ch == CH_SLASH || ch == CH_BSLASH) begin
        w.s.guard = 1'b0;
        w         = f_fin(w, top, cap);
      end else if (ch == CH_HASH || ch == CH_QUEST) begin
        w.s.guard = 1'b0;
        w         = f_fin(w, top, cap);
        w.s.phase = PH_STOP;
      end else if (ch == CH_COLON && w.s.guard) begin
        w.s.rej = 1'b1;
      end else if (ch == CH_PERCENT) begin
        w.s.esc = 2'd1;
      end else begin
        w = f_seg(w, ch);
      end
    end
    return w;
  endfunction

  pstate_t         st;
  logic [CAP_W-1:0] cap;
  logic [OPW-1:0]  cap_eff;
  logic [OPW-1:0]  top;
  logic [OPW-1:0]  second;
  wk_t             wk;
  logic [DW-1:0]   depth_next;
  logic [DW-1:0]   rsub;

  always_comb begin
    if (EW'(cap) > EW'(OUT_DEPTH)) cap_eff = OPW'(OUT_DEPTH);
    else cap_eff = OPW'(cap);
  end

  // Next parse state and the store writes that one item causes.
  always_comb begin : p_work
    wk_t        w;
    logic [7:0] low;
    logic       skip;
    w    = '0;
    w.s  = st;
    low  = '0;
    skip = 1'b0;
    if (command == CMD_PUSH) begin
      if (w.s.phase == PH_DONE) w.s = f_clear();
      if (!w.s.rej && w.s.phase != PH_STOP) begin
        if (w.s.phase == PH_WS) begin
          if (is_ws(char_in)) begin
            skip = 1'b1;
          end else begin
            w.s.phase = PH_PREFIX;
            w.s.pmc   = 3'd0;
          end
        end
        if (!skip && w.s.phase == PH_PREFIX) begin
          if (w.s.pmc == 3'd4 && char_in == CH_COLON) begin
            w.s.raw   = '0;
            w.s.trim  = '0;
            w.s.ft    = '0;
            w.s.guard = 1'b0;
            w.s.phase = PH_BODY;
            skip      = 1'b1;
          end else begin
            low = (char_in >= "A" && char_in <= "Z") ? char_in + 8'd32 : char_in;
            if (w.s.pmc < 3'd4 && low == prefix_char(w.s.pmc[1:0])) begin
              w.s.pmc = w.s.pmc + 3'd1;
            end else begin
              w.s.phase = PH_BODY;
            end
          end
        end
        if (!skip) w = f_body(w, char_in, top, cap_eff);
      end
    end else if (command == CMD_END) begin
      if (w.s.phase != PH_DONE) begin
        if (!w.s.rej && (w.s.phase == PH_PREFIX || w.s.phase == PH_BODY)) begin
          w = f_flush(w);
          w = f_fin(w, top, cap_eff);
        end
        w.s.esc   = 2'd0;
        w.s.raw   = '0;
        w.s.trim  = '0;
        w.s.ft    = '0;
        w.s.phase = PH_DONE;
      end
    end
    wk = w;
  end

  // Result fields of the item.
  always_comb begin
    info.status = ST_OK;
    if (command == CMD_PUSH && wk.s.rej) begin
      info.status = ST_REJECT;
    end else if (command == CMD_END) begin
      info.status = (wk.s.rej || wk.s.op == '0) ? ST_REJECT : ST_DONE;
    end
    info.out_length = LEN_W'(wk.s.op);
    info.rd_hit     = (command == CMD_READ) &&
                      (IW'(read_index) < IW'(st.op)) &&
                      (IW'(read_index) < IW'(OUT_DEPTH));
  end

  assign wr_n    = accept ? wk.wn : 2'd0;
  assign wr_addr = wk.wa;
  assign wr_data = wk.wd;

  // The stack RAM always holds the entry below the top ready for a pop.
  assign depth_next = accept ? wk.s.depth : st.depth;
  assign rsub       = depth_next - DW'(2);

  upn_ram #(
    .WIDTH(OPW),
    .DEPTH(MAX_SEGMENTS)
  ) u_stack (
    .clk  (clk),
    .we   (accept && wk.push),
    .waddr(st.depth[SIW-1:0]),
    .wdata(wk.pushv),
    .raddr(rsub[SIW-1:0]),
    .rdata(second)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= f_clear();
      cap <= CAP_RESET;
    end else begin
      if (accept) st <= wk.s;
      if (cfg_we) cap <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wk.push) begin
      top <= wk.pushv;
    end else if (accept && wk.pop) begin
      top <= second;
    end
  end

endmodule

### sv/uri_path_normalizer.sv
// Top level of the URI path normalizer.
// Depends on upn_pkg, upn_core, upn_write_queue, upn_result_fifo and upn_ram.
//
// Usage: the input channel (in_valid/in_ready) carries one item per command:
// push a path character, end the string, read a normalized byte back, or nop.
// Every item produces exactly one result item on the output channel
// (out_valid/out_ready) with a status, the current normalized length and,
// for a read, the byte at read_index (zero when out of range).
// Accepted items pass the p1 register, then the result FIFO, to out_valid.
// Items are taken one per cycle while in_ready is high; the output store has
// one write port, so a character that writes n bytes (an unfinished escape
// flushed with the next byte, or a segment closed with its separator slash)
// needs n port writes, and the write queue holds ready low while more than
// one write is pending. A read is taken only once the write queue is empty.
// The result FIFO has four entries; when the receiver stalls it fills, and
// in_ready falls before it is full; items resume once results are taken.
// Reset clears the parse state and sets capacity_limit to 4096; the output
// store and segment stack need no clearing pass.
// cfg_we writes capacity_limit from cfg_data.
module uri_path_normalizer #(
  parameter int OUT_DEPTH     = upn_pkg::OUT_DEPTH_DEF,
  parameter int MAX_SEGMENTS  = upn_pkg::MAX_SEGMENTS_DEF,
  parameter int SEGMENT_BYTES = upn_pkg::SEGMENT_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [upn_pkg::CAP_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [upn_pkg::CMD_W-1:0]    command,
  input  logic [upn_pkg::CHAR_W-1:0]   char_in,
  input  logic [upn_pkg::INDEX_W-1:0]  read_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [upn_pkg::STATUS_W-1:0] status,
  output logic [upn_pkg::LEN_W-1:0]    out_length,
  output logic [upn_pkg::CHAR_W-1:0]   read_byte
);
  import upn_pkg::*;

  localparam int AW = $clog2(OUT_DEPTH);

  logic                   accept;
  res_info_t              info;
  logic [1:0]             wr_n;
  logic [2:0][AW-1:0]     wr_addr;
  logic [2:0][CHAR_W-1:0] wr_data;
  logic [2:0]             wq_count;
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [CHAR_W-1:0]      ram_wdata;
  logic [CHAR_W-1:0]      ram_rdata;
  logic [2:0]             fifo_count;
  logic                   p1_valid;
  res_info_t              p1_info;
  res_item_t              item;

  // Room in the result FIFO for this item and the one still in flight, and
  // the write queue nearly drained; reads also wait until all writes landed.
  assign in_ready = ((fifo_count + 3'(p1_valid)) <= 3'd2) &&
                    (wq_count <= 3'd1) &&
                    ((command != CMD_READ) || (wq_count == 3'd0));
  assign accept   = in_valid && in_ready;

  upn_core #(
    .OUT_DEPTH    (OUT_DEPTH),
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .SEGMENT_BYTES(SEGMENT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .command   (command),
    .char_in   (char_in),
    .read_index(read_index),
    .info      (info),
    .wr_n      (wr_n),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  upn_write_queue #(
    .AW(AW)
  ) u_wq (
    .clk      (clk),
    .rst      (rst),
    .push_n   (wr_n),
    .push_addr(wr_addr),
    .push_data(wr_data),
    .count    (wq_count),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata)
  );

  // The store is read at read_index on every cycle; the registered data
  // belongs to the item accepted in the previous cycle.
  upn_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(OUT_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(AW'(read_index)),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) p1_info <= info;
  end

  assign item.status     = p1_info.status;
  assign item.out_length = p1_info.out_length;
  assign item.read_byte  = p1_info.rd_hit ? ram_rdata : '0;

  upn_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (p1_valid),
    .push_item (item),
    .count     (fifo_count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .out_length(out_length),
    .read_byte (read_byte)
  );

endmodule
